FILE: design/lie_pkg.sv
package lie_pkg;

  localparam int DATA_W        = 32;
  localparam int Q_FRAC        = 16;
  localparam int MAX_NODES_DEF = 16;
  localparam int INDEX_W       = 4;
  localparam int DEGREE_W      = 4;
  localparam int STATUS_W      = 2;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVF = 2'd2;

  // register index taken from paddr[2]
  localparam logic REG_DEGREE = 1'b0;

  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd1;

endpackage

FILE: design/lie_if.sv
interface lie_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [lie_pkg::INDEX_W-1:0]          node_index;
  logic signed [lie_pkg::DATA_W-1:0]    node_x;
  logic signed [lie_pkg::DATA_W-1:0]    node_value;
  logic signed [lie_pkg::DATA_W-1:0]    query_point;

  modport source(output valid, kind, node_index, node_x, node_value, query_point,
                 input ready);
  modport sink(input valid, kind, node_index, node_x, node_value, query_point,
               output ready);
endinterface

interface lie_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lie_pkg::DATA_W-1:0]    value;
  logic [lie_pkg::STATUS_W-1:0]         status;

  modport source(output valid, value, status, input ready);
  modport sink(input valid, value, status, output ready);
endinterface

FILE: design/lie_ram.sv
module lie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lagrange_interpolation_eval.sv
// lagrange interpolation evaluator, signed q16.16
// item channel (valid/ready): a load word (kind 0) writes node_x and node_value
//   into node node_index and gives no result; loads at an index at or above
//   MAX_NODES are dropped
// a query word (kind 1) evaluates the lagrange polynomial through nodes
//   0..degree at query_point and gives one word on the result channel:
//   value and status (ok, duplicate abscissa, saturated overflow)
// degree is written over the apb port at byte address 0; the user must write it
//   only while the block is idle, which the block itself does not enforce
// nodes sit in two 1-read/1-write rams; one shared restoring divider (one
//   quotient bit per cycle) and one 32x32 multiplier do all the work
// a duplicate abscissa ends the query as soon as the first zero divisor is seen
// one item is worked at a time
// reset clears the state machine and the result valid flag and sets degree to 1;
//   node storage is not cleared and must be loaded before use
// a stalled result sits in the output register; new items are still taken
//   meanwhile, and a query only waits at its very end for the register
module lagrange_interpolation_eval #(
  parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lie_in_if.sink                           item,
  lie_out_if.source                        result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lie_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lie_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lie_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = (CW > 5) ? CW : 5;
  localparam int W  = lie_pkg::DATA_W;
  localparam int DVW = W + 1;                     // divisor / numerator width
  localparam int QW  = DVW + lie_pkg::Q_FRAC;     // dividend magnitude width
  localparam int DCW = $clog2(QW);
  localparam int PW  = 2 * W;
  localparam int SW  = PW - lie_pkg::Q_FRAC;

  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] Q_ONE = W'(1) << lie_pkg::Q_FRAC;

  typedef enum logic [3:0] {
    S_IDLE, S_JREQ, S_JLAT, S_IREQ, S_ILAT, S_DIV, S_QSAT,
    S_MUL, S_BSCALE, S_TMUL, S_TSCALE, S_ACC, S_DONE
  } state_t;

  state_t state;

  logic [lie_pkg::DEGREE_W-1:0] degree;
  logic [CW-1:0]  j, i;
  logic [CW-1:0]  count;
  logic [EW-1:0]  deg_ext;
  logic signed [W-1:0] t, xj, fj, basis, q, term, sum;
  logic signed [PW-1:0] prod;
  logic           ovf, dup, qneg;
  logic [DVW-1:0] rem, dv;
  logic [QW-1:0]  quo;
  logic [DCW-1:0] dcnt;

  logic           res_valid;
  logic signed [W-1:0] res_value;
  logic [lie_pkg::STATUS_W-1:0] res_status;

  // node storage
  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  logic [W-1:0]   x_rdata, f_rdata;

  assign ram_we = item.valid && item.ready && (item.kind == lie_pkg::KIND_LOAD) &&
                  (EW'(item.node_index) < EW'(MAX_NODES));
  assign ram_waddr = IW'(item.node_index);
  assign ram_raddr = (state == S_JREQ) ? j[IW-1:0] : i[IW-1:0];

  lie_ram #(.WIDTH(W), .DEPTH(MAX_NODES)) u_x_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.node_x),
    .raddr(ram_raddr), .rdata(x_rdata)
  );

  lie_ram #(.WIDTH(W), .DEPTH(MAX_NODES)) u_f_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.node_value),
    .raddr(ram_raddr), .rdata(f_rdata)
  );

  // nodes in use, capped at the storage depth
  assign deg_ext = EW'(degree) + EW'(1);
  assign count   = (deg_ext > EW'(MAX_NODES)) ? CW'(MAX_NODES) : deg_ext[CW-1:0];

  // apb: single register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lie_pkg::REG_DEGREE) ?
                  lie_pkg::APB_DATA_W'(degree) : '0;

  // factor terms from the node just read
  logic signed [DVW-1:0] num, den;
  logic [DVW-1:0] num_mag, den_mag;
  assign num = DVW'(t) - DVW'(signed'(x_rdata));
  assign den = DVW'(xj) - DVW'(signed'(x_rdata));
  assign num_mag = num[DVW-1] ? DVW'(-num) : DVW'(num);
  assign den_mag = den[DVW-1] ? DVW'(-den) : DVW'(den);

  // one restoring division step
  logic [DVW:0] trial;
  logic         fits_div;
  assign trial    = {rem, quo[QW-1]};
  assign fits_div = trial >= {1'b0, dv};

  // shared multiplier
  logic signed [W-1:0] mul_a, mul_b;
  assign mul_a = (state == S_MUL) ? basis : fj;
  assign mul_b = (state == S_MUL) ? q : basis;

  // scale product by 2^-16 toward zero, then saturate
  logic signed [PW-1:0] prod_adj;
  logic signed [SW-1:0] scaled;
  logic                 sc_fit;
  logic signed [W-1:0]  sc_val;
  assign prod_adj = prod + (prod[PW-1] ? PW'((1 << lie_pkg::Q_FRAC) - 1) : PW'(0));
  assign scaled   = SW'(prod_adj >>> lie_pkg::Q_FRAC);
  assign sc_fit   = (&scaled[SW-1:W-1]) || !(|scaled[SW-1:W-1]);
  assign sc_val   = sc_fit ? scaled[W-1:0] : (scaled[SW-1] ? S_MIN : S_MAX);

  // running sum
  logic signed [W:0] acc;
  logic              acc_fit;
  assign acc     = (W+1)'(sum) + (W+1)'(term);
  assign acc_fit = acc[W] == acc[W-1];

  assign item.ready    = (state == S_IDLE);
  assign result.valid  = res_valid;
  assign result.value  = res_value;
  assign result.status = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      degree    <= lie_pkg::DEGREE_RESET;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == lie_pkg::REG_DEGREE)) begin
        degree <= pwdata[lie_pkg::DEGREE_W-1:0];
      end
      // a finishing query refills the register itself
      if (res_valid && result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid && item.kind == lie_pkg::KIND_QUERY) begin
            t     <= item.query_point;
            j     <= '0;
            sum   <= '0;
            ovf   <= 1'b0;
            dup   <= 1'b0;
            state <= S_JREQ;
          end
        end
        S_JREQ: state <= S_JLAT;
        S_JLAT: begin
          xj    <= x_rdata;
          fj    <= f_rdata;
          basis <= Q_ONE;
          i     <= '0;
          state <= S_IREQ;
        end
        S_IREQ: begin
          if (i == count) begin
            state <= S_TMUL;
          end else if (i == j) begin
            i <= i + CW'(1);
          end else begin
            state <= S_ILAT;
          end
        end
        S_ILAT: begin
          // equal abscissas end the query
          if (den == '0) begin
            dup   <= 1'b1;
            state <= S_DONE;
          end else begin
            rem   <= '0;
            quo   <= {num_mag, {lie_pkg::Q_FRAC{1'b0}}};
            dv    <= den_mag;
            qneg  <= num[DVW-1] ^ den[DVW-1];
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= fits_div ? DVW'(trial - {1'b0, dv}) : trial[DVW-1:0];
          quo  <= {quo[QW-2:0], fits_div};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(QW - 1)) begin
            state <= S_QSAT;
          end
        end
        S_QSAT: begin
          if (!qneg && quo > QW'(S_MAX)) begin
            q   <= S_MAX;
            ovf <= 1'b1;
          end else if (qneg && quo > (QW'(1) << (W - 1))) begin
            q   <= S_MIN;
            ovf <= 1'b1;
          end else begin
            q <= qneg ? -signed'(quo[W-1:0]) : signed'(quo[W-1:0]);
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_BSCALE;
        end
        S_BSCALE: begin
          basis <= sc_val;
          ovf   <= ovf | !sc_fit;
          i     <= i + CW'(1);
          state <= S_IREQ;
        end
        S_TMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_TSCALE;
        end
        S_TSCALE: begin
          term  <= sc_val;
          ovf   <= ovf | !sc_fit;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= acc_fit ? acc[W-1:0] : (acc[W] ? S_MIN : S_MAX);
          ovf <= ovf | !acc_fit;
          j   <= j + CW'(1);
          state <= ((j + CW'(1)) == count) ? S_DONE : S_JREQ;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_value  <= dup ? '0 : sum;
            res_status <= dup ? lie_pkg::STATUS_DUP :
                          (ovf ? lie_pkg::STATUS_OVF : lie_pkg::STATUS_OK);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
